// ===== rtl/mspd_pkg.sv =====
// Shared types and constants of the magic-sync packet deframer.
// Depends on nothing; the front end, queue, top level and testbench import it.
`default_nettype none
package mspd_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam int unsigned STORE_BYTES = 20;
	localparam int unsigned STORE_W = STORE_BYTES * 8;

	localparam logic [23:0] MAGIC_HEAD = 24'h415643;
	localparam logic [7:0] MAGIC_TAIL = 8'h31;
	localparam logic [4:0] STORE_LAST = 5'd19;
	localparam logic [4:0] HDR_LAST = 5'd23;
	localparam logic [1:0] FILL_FULL = 2'd3;
	localparam logic [31:0] MAX_LEN_RESET = 32'd8388608;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_HEADER = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] data_byte;
		logic last;
		logic [31:0] frame_width;
		logic [31:0] frame_height;
		logic [31:0] frame_flags;
		logic [63:0] header_extra;
		logic [31:0] payload_length;
	} res_t;

	typedef struct packed {
		logic push;
		res_t data;
	} push_t;

endpackage
`default_nettype wire

// ===== rtl/mspd_if.sv =====
// Stream interfaces of the deframer: raw bytes in, result beats out.
// Both carry valid, ready and the payload fields; no package needed.
`default_nettype none
interface mspd_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface mspd_out_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic last;
	logic [31:0] frame_width;
	logic [31:0] frame_height;
	logic [31:0] frame_flags;
	logic [63:0] header_extra;
	logic [31:0] payload_length;

	modport source (output valid, output kind, output data_byte, output last,
		output frame_width, output frame_height, output frame_flags,
		output header_extra, output payload_length, input ready);
	modport sink (input valid, input kind, input data_byte, input last,
		input frame_width, input frame_height, input frame_flags,
		input header_extra, input payload_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/mspd_front.sv =====
// Front end: accepts stream beats, hunts for the magic, collects the header
// and emits header, rejected-header and payload result beats. Uses mspd_pkg and mspd_in_if.
`default_nettype none
module mspd_front (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	mspd_in_if.sink stream,
	input logic q_full,
	output mspd_pkg::push_t push_o
);
	import mspd_pkg::*;

	phase_t phase_q, phase_d;
	logic [23:0] win_q, win_d;
	logic [1:0] fill_q, fill_d;
	logic [4:0] idx_q, idx_d;
	logic [STORE_W-1:0] store_q, store_d;
	logic [31:0] len_q, len_d;
	logic [31:0] rem_q, rem_d;
	logic [31:0] max_q;

	logic accept;
	logic [7:0] b;
	logic [31:0] len_full;
	logic [31:0] rem_dec;
	logic hdr_done;
	logic reject;
	logic match;

	assign stream.ready = !q_full;
	assign accept = stream.valid && !q_full;
	assign b = stream.in_byte;
	assign len_full = {len_q[23:0], b};
	assign rem_dec = (rem_q == '0) ? '0 : rem_q - 32'd1;
	assign hdr_done = (idx_q == HDR_LAST);
	assign reject = (len_full == '0) || (len_full > max_q);
	assign match = (fill_q == FILL_FULL) && (win_q == MAGIC_HEAD) && (b == MAGIC_TAIL);

	always_comb begin
		phase_d = phase_q;
		win_d = win_q;
		fill_d = fill_q;
		idx_d = idx_q;
		store_d = store_q;
		len_d = len_q;
		rem_d = rem_q;
		if (accept) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (idx_q <= STORE_LAST) begin
						store_d = {store_q[STORE_W-9:0], b};
					end else begin
						len_d = len_full;
					end
					idx_d = idx_q + 5'd1;
					if (hdr_done) begin
						idx_d = '0;
						if (reject) begin
							phase_d = PH_HUNT;
							win_d = '0;
							fill_d = '0;
						end else begin
							phase_d = PH_PAYLOAD;
							rem_d = len_full;
						end
					end
				end
				PH_PAYLOAD: begin
					rem_d = rem_dec;
					if (rem_dec == '0) begin
						phase_d = PH_HUNT;
						win_d = '0;
						fill_d = '0;
					end
				end
				default: begin
					phase_d = PH_HUNT;
					if (match) begin
						phase_d = PH_HEADER;
						idx_d = '0;
						len_d = '0;
						win_d = '0;
						fill_d = '0;
					end else begin
						win_d = {win_q[15:0], b};
						if (fill_q != FILL_FULL) begin
							fill_d = fill_q + 2'd1;
						end
					end
				end
			endcase
		end
	end

	always_comb begin
		push_o = '0;
		if (accept) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (hdr_done) begin
						push_o.push = 1'b1;
						push_o.data.kind = reject ? KIND_REJECT : KIND_HEADER;
						push_o.data.frame_width = store_q[159:128];
						push_o.data.frame_height = store_q[127:96];
						push_o.data.frame_flags = store_q[95:64];
						push_o.data.header_extra = store_q[63:0];
						push_o.data.payload_length = len_full;
					end
				end
				PH_PAYLOAD: begin
					push_o.push = 1'b1;
					push_o.data.kind = KIND_PAYLOAD;
					push_o.data.data_byte = b;
					push_o.data.last = (rem_dec == '0);
					push_o.data.payload_length = len_q;
				end
				default: begin
					push_o.push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			win_q <= '0;
			fill_q <= '0;
			idx_q <= '0;
			len_q <= '0;
			rem_q <= '0;
			max_q <= MAX_LEN_RESET;
		end else begin
			phase_q <= phase_d;
			win_q <= win_d;
			fill_q <= fill_d;
			idx_q <= idx_d;
			len_q <= len_d;
			rem_q <= rem_d;
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		store_q <= store_d;
	end

`ifndef NO_ASSERTIONS
	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> rem_q != '0)
		else $error("payload phase with no bytes remaining");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> idx_q <= HDR_LAST)
		else $error("header index out of range");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_o.push |-> !q_full)
		else $error("result pushed into a full queue");
`endif

endmodule
`default_nettype wire

// ===== rtl/mspd_queue.sv =====
// Result queue between the front end and the output channel.
// A small register array with head and tail pointers; uses mspd_pkg.
`default_nettype none
module mspd_queue (
	input logic clk,
	input logic arst_n,
	input mspd_pkg::push_t push_i,
	output logic full,
	mspd_out_if.source result
);
	import mspd_pkg::*;

	res_t mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic pop;
	res_t head;

	assign full = (count_q == QCNT_W'(QDEPTH));
	assign pop = result.valid && result.ready;
	assign head = mem[rd_ptr_q];

	assign result.valid = (count_q != '0);
	assign result.kind = head.kind;
	assign result.data_byte = head.data_byte;
	assign result.last = head.last;
	assign result.frame_width = head.frame_width;
	assign result.frame_height = head.frame_height;
	assign result.frame_flags = head.frame_flags;
	assign result.header_extra = head.header_extra;
	assign result.payload_length = head.payload_length;

	always_ff @(posedge clk) begin
		if (push_i.push) begin
			mem[wr_ptr_q] <= push_i.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push_i.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push_i.push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push_i.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count exceeds depth");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push_i.push && count_q == QCNT_W'(1)) |=> !result.valid)
		else $error("queue not empty after its last entry left");
`endif

endmodule
`default_nettype wire

// ===== rtl/magic_sync_packet_deframer.sv =====
// Top level of the magic-sync packet deframer: front end plus result queue.
// Depends on mspd_pkg, mspd_if, mspd_front and mspd_queue.
//
//   channel   direction  handshake      beat
//   stream    in         valid/ready    one raw stream byte
//   result    out        valid/ready    one header, rejected-header or payload result
//   cfg       in         cfg_we only    max_payload_length, 32 bits
//
// One stream beat is accepted every cycle while the result queue has room.
// A result is registered in the result queue and is driven out from the queue head.
// The four-entry result queue sets when the input stalls: ready falls when it is full.
// Reset is asynchronous and takes effect at once; there is no clearing pass.
`default_nettype none
module magic_sync_packet_deframer (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	mspd_in_if.sink stream,
	mspd_out_if.source result
);
	import mspd_pkg::*;

	push_t push;
	logic q_full;

	mspd_front u_front (
		.clk (clk),
		.arst_n (arst_n),
		.cfg_we (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stream (stream),
		.q_full (q_full),
		.push_o (push)
	);

	mspd_queue u_queue (
		.clk (clk),
		.arst_n (arst_n),
		.push_i (push),
		.full (q_full),
		.result (result)
	);

endmodule
`default_nettype wire

// ===== tb/sv/magic_sync_packet_deframer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for magic_sync_packet_deframer: byte stream in, header,
// reject and payload beats out, each compared with an in-bench predictor.
// Depends on mspd_pkg, the mspd_in_if/mspd_out_if interfaces and the RTL top level.
module magic_sync_packet_deframer_tb;
	import mspd_pkg::*;

	localparam int CLK_HALF = 10;
	localparam int LIMIT_CYCLES = 300000;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_BYTES = 100;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [31:0] cfg_wdata;

	mspd_in_if stream_if();
	mspd_out_if result_if();

	magic_sync_packet_deframer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.stream(stream_if),
		.result(result_if)
	);

	// Predictor state.
	logic [31:0] max_len = MAX_LEN_RESET;
	logic [23:0] hunt_window = '0;
	logic [1:0] hunt_fill = '0;
	phase_t frame_phase = PH_HUNT;
	logic [4:0] hdr_count = '0;
	logic [7:0] hdr_bytes [STORE_BYTES];
	logic [31:0] len_word = '0;
	logic [31:0] bytes_left = '0;

	res_t pending_results[$];

	int errors = 0;
	int cycles = 0;
	int in_beats = 0;
	int in_stalls = 0;
	int headers_seen = 0;
	int rejects_seen = 0;
	int payload_seen = 0;
	int max_writes = 0;
	int holds_asked = 0;
	int holds_granted = 0;
	bit gaps_on = 1'b1;
	int burst_left = 0;

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
		r = '0;
		case (frame_phase)
		PH_HEADER: begin
			if (hdr_count <= STORE_LAST)
				hdr_bytes[hdr_count] = b;
			else
				len_word = {len_word[23:0], b};
			if (hdr_count != HDR_LAST) begin
				hdr_count++;
				return 1'b0;
			end
			hdr_count = '0;
			r.frame_width = {hdr_bytes[0], hdr_bytes[1], hdr_bytes[2], hdr_bytes[3]};
			r.frame_height = {hdr_bytes[4], hdr_bytes[5], hdr_bytes[6], hdr_bytes[7]};
			r.frame_flags = {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], hdr_bytes[11]};
			r.header_extra = {hdr_bytes[12], hdr_bytes[13], hdr_bytes[14], hdr_bytes[15],
				hdr_bytes[16], hdr_bytes[17], hdr_bytes[18], hdr_bytes[19]};
			r.payload_length = len_word;
			if (len_word == '0 || len_word > max_len) begin
				r.kind = KIND_REJECT;
				frame_phase = PH_HUNT;
				hunt_fill = '0;
				hunt_window = '0;
			end else begin
				r.kind = KIND_HEADER;
				bytes_left = len_word;
				frame_phase = PH_PAYLOAD;
			end
			return 1'b1;
		end
		PH_PAYLOAD: begin
			r.kind = KIND_PAYLOAD;
			r.data_byte = b;
			r.payload_length = len_word;
			if (bytes_left != '0)
				bytes_left--;
			if (bytes_left == '0) begin
				r.last = 1'b1;
				frame_phase = PH_HUNT;
				hunt_fill = '0;
				hunt_window = '0;
			end
			return 1'b1;
		end
		default: begin
			frame_phase = PH_HUNT;
			if (hunt_fill == FILL_FULL && hunt_window == MAGIC_HEAD && b == MAGIC_TAIL) begin
				frame_phase = PH_HEADER;
				hdr_count = '0;
				len_word = '0;
				hunt_fill = '0;
				hunt_window = '0;
				return 1'b0;
			end
			hunt_window = {hunt_window[15:0], b};
			if (hunt_fill != FILL_FULL)
				hunt_fill++;
			return 1'b0;
		end
		endcase
	endfunction

	always @(posedge clk) begin : beat_monitor
		res_t want;
		if (arst_n) begin
			if (result_if.valid && result_if.ready) begin
				case (result_if.kind)
				KIND_HEADER: headers_seen++;
				KIND_REJECT: rejects_seen++;
				default: payload_seen++;
				endcase
				if (pending_results.size() == 0) begin
					$error("result beat with no expected result waiting");
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (result_if.kind != want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, result_if.kind);
						errors++;
					end
					if (result_if.data_byte != want.data_byte) begin
						$error("data_byte: expected %02h, got %02h",
							want.data_byte, result_if.data_byte);
						errors++;
					end
					if (result_if.last != want.last) begin
						$error("last: expected %0d, got %0d", want.last, result_if.last);
						errors++;
					end
					if (result_if.frame_width != want.frame_width) begin
						$error("frame_width: expected %08h, got %08h",
							want.frame_width, result_if.frame_width);
						errors++;
					end
					if (result_if.frame_height != want.frame_height) begin
						$error("frame_height: expected %08h, got %08h",
							want.frame_height, result_if.frame_height);
						errors++;
					end
					if (result_if.frame_flags != want.frame_flags) begin
						$error("frame_flags: expected %08h, got %08h",
							want.frame_flags, result_if.frame_flags);
						errors++;
					end
					if (result_if.header_extra != want.header_extra) begin
						$error("header_extra: expected %016h, got %016h",
							want.header_extra, result_if.header_extra);
						errors++;
					end
					if (result_if.payload_length != want.payload_length) begin
						$error("payload_length: expected %08h, got %08h",
							want.payload_length, result_if.payload_length);
						errors++;
					end
				end
			end
			if (stream_if.valid && stream_if.ready) begin
				in_beats++;
				if (deframe_byte(stream_if.in_byte, want))
					pending_results.push_back(want);
			end else if (stream_if.valid) begin
				in_stalls++;
			end
		end
	end

	initial begin : result_stall
		int hold_left;
		int mode;
		int mode_left;
		int tick;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		tick = 0;
		result_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_left == 0 && holds_granted < holds_asked) begin
				holds_granted++;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(10, 60);
			end else begin
				mode_left--;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else begin
				case (mode)
				0: result_if.ready <= 1'b1;
				1: result_if.ready <= $urandom_range(0, 1);
				2: result_if.ready <= ($urandom_range(0, 3) == 0);
				default: result_if.ready <= ((tick % 7) < 5);
				endcase
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		stream_if.valid <= 1'b1;
		stream_if.in_byte <= b;
		@(posedge clk);
		while (!stream_if.ready)
			@(posedge clk);
		if (gaps_on) begin
			if (burst_left == 0) begin
				stream_if.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_header_body(input logic [159:0] hdr, input logic [31:0] len);
		for (int i = 0; i < 20; i++)
			send_byte(hdr[159 - 8 * i -: 8]);
		for (int i = 0; i < 4; i++)
			send_byte(len[31 - 8 * i -: 8]);
	endtask

	task automatic send_payload(input int n);
		for (int i = 0; i < n; i++)
			send_byte($urandom_range(0, 255));
	endtask

	task automatic send_packet(input logic [159:0] hdr, input logic [31:0] len);
		send_text("AVC1");
		send_header_body(hdr, len);
		if (len != '0 && len <= max_len)
			send_payload(len);
	endtask

	task automatic wait_idle();
		stream_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max(input logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		max_len = v;
		max_writes++;
	endtask

	function automatic logic [159:0] random_header();
		return {$urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	task automatic test_reset_limit();
		gaps_on = 1'b0;
		send_packet('0, 32'd1);
		send_packet('1, MAX_LEN_RESET + 32'd1);
		send_packet(random_header(), 32'd0);
		send_packet('1, 32'd3);
		wait_idle();
	endtask

	task automatic test_hunt_sync();
		gaps_on = 1'b1;
		send_text("AVAVC1");
		send_header_body(random_header(), 32'd2);
		send_payload(2);
		send_text("AAVC1");
		send_header_body({5{32'h41564331}}, 32'd4);
		send_text("AVC1");
		send_text("AVCx1AVC");
		send_text("AVC1");
		send_header_body(random_header(), 32'd3);
		send_text("AVC");
		send_text("1VC1");
		send_packet(random_header(), 32'd1);
		wait_idle();
	endtask

	task automatic test_length_bounds();
		gaps_on = 1'b1;
		write_max(32'd5);
		send_packet(random_header(), 32'd5);
		send_packet(random_header(), 32'd6);
		send_packet(random_header(), {8'h00, MAGIC_HEAD});
		send_text("1");
		send_packet(random_header(), 32'd1);
		wait_idle();
		write_max(32'd1);
		send_packet(random_header(), 32'd1);
		send_packet(random_header(), 32'd2);
		wait_idle();
		write_max(32'd0);
		send_packet(random_header(), 32'd1);
		send_packet(random_header(), 32'd0);
		wait_idle();
		write_max(32'hFFFF_FFFE);
		send_packet(random_header(), 32'hFFFF_FFFF);
		send_packet(random_header(), 32'd2);
		wait_idle();
		write_max(32'hFFFF_FFFF);
		send_packet(random_header(), 32'd4);
		send_packet(random_header(), 32'd0);
		wait_idle();
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		write_max(MAX_LEN_RESET);
		holds_asked++;
		send_packet(random_header(), 32'd24);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int framed;
		int pick;
		int n;
		logic [31:0] len;
		framed = 0;
		while (framed < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			gaps_on = ($urandom_range(0, 3) != 0);
			if (pick < 6) begin
				wait_idle();
				case ($urandom_range(0, 5))
				0: write_max(32'd1);
				1: write_max(32'd4);
				2: write_max(32'hFFFF_FFFF);
				3: write_max(MAX_LEN_RESET);
				default: write_max($urandom_range(1, 40));
				endcase
			end else if (pick < 18) begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++) begin
					case ($urandom_range(0, 5))
					0: send_text("A");
					1: send_text("V");
					2: send_text("C");
					3: send_text("1");
					default: send_byte($urandom_range(0, 255));
					endcase
				end
			end else if (pick < 24) begin
				send_text($urandom_range(0, 1) ? "AV" : "AVC");
				send_byte($urandom_range(0, 255));
			end else begin
				case ($urandom_range(0, 9))
				0: len = '0;
				1: len = (max_len == 32'hFFFF_FFFF) ? '0 :
					max_len + 32'd1 + ($urandom % (~max_len));
				2: len = $urandom_range(17, 48);
				default: len = $urandom_range(1, 16);
				endcase
				send_packet(random_header(), len);
				framed += 28;
				if (len != '0 && len <= max_len)
					framed += len;
			end
		end
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		stream_if.valid = 1'b0;
		stream_if.in_byte = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_limit();
		test_hunt_sync();
		test_length_bounds();
		test_backpressure();
		test_random_traffic();
		$display("Covered %0d stream beats with %0d stalled cycles, %0d headers, %0d rejects.",
			in_beats, in_stalls, headers_seen, rejects_seen);
		$display("Saw %0d payload beats over %0d limit writes and %0d long receiver holds.",
			payload_seen, max_writes, holds_granted);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/mspd_pkg.sv
rtl/mspd_if.sv
rtl/mspd_front.sv
rtl/mspd_queue.sv
rtl/magic_sync_packet_deframer.sv
tb/sv/magic_sync_packet_deframer_tb.sv
